// ----- hdl/sine_cosine_polynomial_macros.svh -----
// assertion macros shared by the sine/cosine pipeline modules
`ifndef SINE_COSINE_POLYNOMIAL_MACROS_SVH
`define SINE_COSINE_POLYNOMIAL_MACROS_SVH

`ifndef ASSERT_OFF
// checked on every rising edge outside reset
`define SCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every rising edge, reset included
`define SCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SCP_ASSERT(lbl, prop, msg)
`define SCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/scp_pkg.sv -----
// constants and widths for the sine/cosine polynomial pipeline
`default_nettype none

package scp_pkg;

    // field widths
    localparam int ANGLE_W  = 24;
    localparam int RESULT_W = 18;

    // opcodes
    localparam logic OP_SINE   = 1'b0;
    localparam logic OP_COSINE = 1'b1;

    // angle reduction, q32 radians
    localparam int V_W  = 42;
    localparam int WQ_W = V_W - 24;
    localparam int K_W  = 7;
    localparam int KP_W = K_W + 36;
    localparam int R_W  = 38;
    localparam int X_W  = 31;

    localparam logic signed [V_W-1:0] PI_Q32      = 42'sh003243F6A89;
    localparam logic signed [V_W-1:0] NEG_PI_Q32  = -42'sh003243F6A89;
    localparam logic signed [V_W-1:0] HALF_PI_Q32 = 42'sh001921FB544;
    localparam logic signed [35:0]    TWO_PI_Q32  = 36'sh6487ED511;

    // reduction window edges, at the working width of the remainder
    localparam logic signed [R_W-1:0] PI_R       = 38'sh03243F6A89;
    localparam logic signed [R_W-1:0] NEG_PI_R   = -38'sh03243F6A89;
    localparam logic signed [R_W-1:0] TWO_PI_R   = 38'sh06487ED511;
    localparam logic signed [R_W-1:0] PI_LESS_2PI = -38'sh03243F6A88;
    localparam logic signed [R_W-1:0] TWO_PI_LESS_PI = 38'sh03243F6A88;

    // 2^24 / (2*pi), used to estimate the turn count
    localparam logic signed [22:0] RECIP_2PI = 23'sd2670177;

    // largest reduced angle magnitude in q28
    localparam logic signed [X_W-1:0] X_MAX = 31'sd843314857;
    localparam logic signed [X_W-1:0] X_MIN = -31'sd843314857;

    // polynomial coefficients, q28
    localparam logic signed [29:0] Q28_ONE = 30'sd268435456;
    localparam logic signed [26:0] Q28_C3  = -27'sd44739244;
    localparam logic signed [22:0] Q28_C5  = 23'sd2236962;
    localparam logic signed [16:0] Q28_C7  = 17'sd53260;

    // rounding offsets
    localparam logic signed [63:0] RND_28 = 64'sd134217728;
    localparam logic signed [63:0] RND_12 = 64'sd2048;
    localparam logic signed [R_W-1:0] RND_4 = 38'sd8;

    localparam logic signed [RESULT_W-1:0] RESULT_MAX = 18'sd131071;
    localparam logic signed [RESULT_W-1:0] RESULT_MIN = -18'sd131072;

    // pipeline depths
    localparam int RED_STAGES = 6;
    localparam int HOR_STAGES = 11;

    // which side of the principal window the unreduced angle lies on
    typedef struct packed {
        logic above;
        logic below;
    } t_scp_side;

endpackage

`default_nettype wire

// ----- hdl/sine_cosine_polynomial.sv -----
// top level of the sine/cosine polynomial unit
// Sine or cosine of a signed q8.16 angle in radians, returned as a signed
// q2.16 value rounded to nearest and saturated. Cosine adds pi/2 to the
// angle, the angle is then folded into [-pi, pi] by whole turns of 2*pi and
// fed to the odd degree-7 polynomial x*(1 + x^2*(-1/6 + x^2*(c5 - x^2*c7)))
// in q28. The unit is a stall-able pipeline: it takes one word on every
// clock cycle while the output side is not stalled. A word passes through
// the angle reduction stages and then the polynomial stages, in which each
// registered multiply is followed by a rounding stage. Empty stages keep
// absorbing words while a result waits on the output, so the input only
// stalls once the whole pipeline is full. There is no configuration and
// nothing is kept between words.
`default_nettype none

module sine_cosine_polynomial
    import scp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [23:0] angle, signed q8.16
    input  wire logic [0:0]  s_axis_tuser,   // [0] opcode, 0 sine, 1 cosine
    // result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // [17:0] result, signed q2.16
);

    logic                       w_red_valid;
    logic                       w_hor_ready;
    logic signed [X_W-1:0]      w_x;
    logic signed [RESULT_W-1:0] w_result;
    logic signed [ANGLE_W-1:0]  w_angle;

    // unpack the angle from the input word
    assign w_angle = s_axis_tdata[ANGLE_W-1:0];

    // phase offset and folding into the principal window
    scp_reduce u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_opcode (s_axis_tuser[0]),
        .i_angle  (w_angle),
        .o_valid  (w_red_valid),
        .i_ready  (w_hor_ready),
        .o_x      (w_x)
    );

    // polynomial, final rounding and clamp; its last stage is the output register
    scp_horner u_horner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_red_valid),
        .o_ready  (w_hor_ready),
        .i_x      (w_x),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    // pack the result, upper bits zero to fill the word
    assign m_axis_tdata = {{(24-RESULT_W){1'b0}}, w_result};

endmodule

`default_nettype wire

// ----- hdl/scp_reduce.sv -----
// phase offset and reduction of the angle into [-pi, pi], output in q28
`default_nettype none
`include "sine_cosine_polynomial_macros.svh"

module scp_reduce
    import scp_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_opcode,
    input  wire logic signed [ANGLE_W-1:0]   i_angle,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic signed [X_W-1:0]            o_x
);

    logic [RED_STAGES-1:0] r_vld;
    logic [RED_STAGES-1:0] w_rdy;

    logic signed [V_W-1:0]  r_v1, r_v2, r_v3;
    logic signed [WQ_W-1:0] r_wq2;
    logic signed [K_W-1:0]  r_k3;
    logic signed [R_W-1:0]  r_r4, r_v4, r_r5;
    logic signed [X_W-1:0]  r_x6;
    t_scp_side              r_side2, r_side3, r_side4;

    logic signed [V_W-1:0]  n_v1;
    logic signed [V_W-1:0]  n_w;
    t_scp_side              n_side2;
    logic signed [40:0]     n_prod;
    logic signed [KP_W-1:0] n_kp;
    logic signed [KP_W:0]   n_r0;
    logic signed [R_W-1:0]  n_r5;
    logic signed [R_W-1:0]  n_xs;

    // stall chain, a stage loads when empty or when its successor moves
    always_comb begin
        w_rdy[RED_STAGES-1] = !r_vld[RED_STAGES-1] || i_ready;
        for (int i = RED_STAGES - 2; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < RED_STAGES; i++) begin
                if (w_rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_comb begin
        // q8.16 to q32, plus quarter turn for cosine
        n_v1 = {{(V_W-ANGLE_W-16){i_angle[ANGLE_W-1]}}, i_angle, 16'b0};
        if (i_opcode == OP_COSINE) begin
            n_v1 = n_v1 + HALF_PI_Q32;
        end
        // turn estimate works on the angle shifted up by half a turn
        n_w           = r_v1 + PI_Q32;
        n_side2.above = r_v1 > PI_Q32;
        n_side2.below = r_v1 < NEG_PI_Q32;
        n_prod        = r_wq2 * RECIP_2PI;
        n_kp          = r_k3 * TWO_PI_Q32;
        n_r0          = {{(KP_W+1-V_W){r_v3[V_W-1]}}, r_v3} - {n_kp[KP_W-1], n_kp};
        // the estimate is off by at most one turn, one step fixes it
        n_r5 = r_r4;
        priority if (r_side4.above) begin
            if (r_r4 > PI_R) begin
                n_r5 = r_r4 - TWO_PI_R;
            end else if (r_r4 <= PI_LESS_2PI) begin
                n_r5 = r_r4 + TWO_PI_R;
            end
        end else if (r_side4.below) begin
            if (r_r4 < NEG_PI_R) begin
                n_r5 = r_r4 + TWO_PI_R;
            end else if (r_r4 >= TWO_PI_LESS_PI) begin
                n_r5 = r_r4 - TWO_PI_R;
            end
        end else begin
            n_r5 = r_v4;
        end
        // q32 to q28, round half up
        n_xs = r_r5 + RND_4;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_v1 <= n_v1;
        end
        if (w_rdy[1]) begin
            r_v2    <= r_v1;
            r_wq2   <= n_w[V_W-1:24];
            r_side2 <= n_side2;
        end
        if (w_rdy[2]) begin
            r_v3    <= r_v2;
            r_k3    <= n_prod[32+K_W-1:32];
            r_side3 <= r_side2;
        end
        if (w_rdy[3]) begin
            r_r4    <= n_r0[R_W-1:0];
            r_v4    <= r_v3[R_W-1:0];
            r_side4 <= r_side3;
        end
        if (w_rdy[4]) begin
            r_r5 <= n_r5;
        end
        if (w_rdy[5]) begin
            r_x6 <= n_xs[X_W+3:4];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[RED_STAGES-1];
    assign o_x     = r_x6;

    `SCP_ASSERT(a_x_in_window, r_vld[RED_STAGES-1] |-> (r_x6 <= X_MAX && r_x6 >= X_MIN), "reduced angle outside [-pi, pi]")
    `SCP_ASSERT_ALWAYS(a_red_reset_empty, !i_rst_n |=> (r_vld == '0), "reduction stages hold a word after reset")

endmodule

`default_nettype wire

// ----- hdl/scp_horner.sv -----
// horner evaluation of the odd degree-7 polynomial, rounding and saturation
`default_nettype none
`include "sine_cosine_polynomial_macros.svh"

module scp_horner
    import scp_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [X_W-1:0]        i_x,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [RESULT_W-1:0]        o_result
);

    localparam int S_W  = 33;
    localparam int T1_W = 24;
    localparam int T2_W = 30;
    localparam int T3_W = 31;
    localparam int Q_W  = 32;
    localparam int P1_W = 2 * X_W;
    localparam int P3_W = S_W + 17;
    localparam int P5_W = S_W + T1_W;
    localparam int P7_W = S_W + T2_W;
    localparam int P9_W = X_W + T3_W;

    logic [HOR_STAGES-1:0] r_vld;
    logic [HOR_STAGES-1:0] w_rdy;

    logic signed [X_W-1:0]   r_x1, r_x2, r_x3, r_x4, r_x5, r_x6, r_x7, r_x8;
    logic signed [P1_W-1:0]  r_p1;
    logic signed [S_W-1:0]   r_s2, r_s3, r_s4, r_s5, r_s6;
    logic signed [P3_W-1:0]  r_p3;
    logic signed [T1_W-1:0]  r_t4;
    logic signed [P5_W-1:0]  r_p5;
    logic signed [T2_W-1:0]  r_t6;
    logic signed [P7_W-1:0]  r_p7;
    logic signed [T3_W-1:0]  r_t8;
    logic signed [P9_W-1:0]  r_p9;
    logic signed [Q_W-1:0]   r_q10;
    logic signed [RESULT_W-1:0] r_res11;

    logic signed [P1_W-1:0]  n_p1, n_sum2;
    logic signed [P3_W-1:0]  n_p3, n_sum4;
    logic signed [P5_W-1:0]  n_p5, n_sum6;
    logic signed [P7_W-1:0]  n_p7, n_sum8;
    logic signed [P9_W-1:0]  n_p9, n_sum10;
    logic signed [T1_W-1:0]  n_t4;
    logic signed [T2_W-1:0]  n_t6;
    logic signed [T3_W-1:0]  n_t8;
    logic signed [Q_W-1:0]   n_sum11;
    logic signed [Q_W-13:0]  n_z;
    logic signed [RESULT_W-1:0] n_res;

    always_comb begin
        w_rdy[HOR_STAGES-1] = !r_vld[HOR_STAGES-1] || i_ready;
        for (int i = HOR_STAGES - 2; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < HOR_STAGES; i++) begin
                if (w_rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // each product is registered, the q28 rounding sits in the stage after
    always_comb begin
        n_p1   = i_x * i_x;
        n_sum2 = r_p1 + P1_W'(RND_28);
        n_p3   = r_s2 * Q28_C7;
        n_sum4 = r_p3 + P3_W'(RND_28);
        n_t4   = T1_W'(Q28_C5) - {{(T1_W-(P3_W-28)){n_sum4[P3_W-1]}}, n_sum4[P3_W-1:28]};
        n_p5   = r_s4 * r_t4;
        n_sum6 = r_p5 + P5_W'(RND_28);
        n_t6   = T2_W'(Q28_C3) + {{(T2_W-(P5_W-28)){n_sum6[P5_W-1]}}, n_sum6[P5_W-1:28]};
        n_p7   = r_s6 * r_t6;
        n_sum8 = r_p7 + P7_W'(RND_28);
        n_t8   = T3_W'(Q28_ONE) + n_sum8[T3_W+27:28];
        n_p9   = r_x8 * r_t8;
        n_sum10 = r_p9 + P9_W'(RND_28);
        // q28 to q16, round half up, then clamp to the field
        n_sum11 = r_q10 + Q_W'(RND_12);
        n_z     = n_sum11[Q_W-1:12];
        priority if (n_z > (Q_W-12)'(RESULT_MAX)) begin
            n_res = RESULT_MAX;
        end else if (n_z < (Q_W-12)'(RESULT_MIN)) begin
            n_res = RESULT_MIN;
        end else begin
            n_res = n_z[RESULT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_p1 <= n_p1;
            r_x1 <= i_x;
        end
        if (w_rdy[1]) begin
            r_s2 <= n_sum2[S_W+27:28];
            r_x2 <= r_x1;
        end
        if (w_rdy[2]) begin
            r_p3 <= n_p3;
            r_s3 <= r_s2;
            r_x3 <= r_x2;
        end
        if (w_rdy[3]) begin
            r_t4 <= n_t4;
            r_s4 <= r_s3;
            r_x4 <= r_x3;
        end
        if (w_rdy[4]) begin
            r_p5 <= n_p5;
            r_s5 <= r_s4;
            r_x5 <= r_x4;
        end
        if (w_rdy[5]) begin
            r_t6 <= n_t6;
            r_s6 <= r_s5;
            r_x6 <= r_x5;
        end
        if (w_rdy[6]) begin
            r_p7 <= n_p7;
            r_x7 <= r_x6;
        end
        if (w_rdy[7]) begin
            r_t8 <= n_t8;
            r_x8 <= r_x7;
        end
        if (w_rdy[8]) begin
            r_p9 <= n_p9;
        end
        if (w_rdy[9]) begin
            r_q10 <= n_sum10[Q_W+27:28];
        end
        if (w_rdy[10]) begin
            r_res11 <= n_res;
        end
    end

    assign o_ready  = w_rdy[0];
    assign o_valid  = r_vld[HOR_STAGES-1];
    assign o_result = r_res11;

    `SCP_ASSERT(a_square_nonneg, r_vld[1] |-> !r_s2[S_W-1], "rounded square of the angle is negative")
    `SCP_ASSERT(a_s_carried, (r_vld[2] && $past(w_rdy[2])) |-> (r_s3 == $past(r_s2)), "square lost between stages")
    `SCP_ASSERT_ALWAYS(a_hor_reset_empty, !i_rst_n |=> (r_vld == '0), "polynomial stages hold a word after reset")

endmodule

`default_nettype wire

// ----- tb/sv/tb_sine_cosine_polynomial.sv -----
// self-checking testbench for the sine/cosine polynomial unit
module tb_sine_cosine_polynomial;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 650;
    localparam int IDLE_PCT     = 28;
    // slack after the last expected result, to catch stray words
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 200000;
    // words in this index range are sent and taken with no idling on either side
    localparam int CALM_FIRST   = 300;
    localparam int CALM_LAST    = 419;

    // angle handling in q32 radians
    localparam longint HALF_TURN_Q32    = 64'h3243F6A89;
    localparam longint FULL_TURN_Q32    = 64'h6487ED511;
    localparam longint QUARTER_TURN_Q32 = 64'h1921FB544;
    // polynomial coefficients in q28
    localparam longint UNIT_Q28  = 268435456;
    localparam longint COEF3_Q28 = -44739244;
    localparam longint COEF5_Q28 = 2236962;
    localparam longint COEF7_Q28 = 53260;
    localparam longint SAT_HIGH  = 131071;
    localparam longint SAT_LOW   = -131072;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // [23:0] angle, signed q8.16
    logic [0:0]  s_axis_tuser  = '0;   // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [17:0] result, signed q2.16

    typedef struct packed {
        logic        op;
        logic [23:0] angle;
        logic        known;    // result below is typed in, not predicted
        logic [17:0] result;
    } t_stim_row;

    typedef struct {
        logic               op;
        logic signed [23:0] angle;
        logic signed [17:0] result;
    } t_sincos_word;

    // directed words: zero, the extremes, both sides of the pi and -pi boundaries
    // (for sine and after the cosine shift) and of 3*pi, whole turns and bit patterns
    localparam int N_DIRECTED = 23;
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{scp_pkg::OP_SINE,   24'd0,          1'b1, 18'd0},
        '{scp_pkg::OP_COSINE, 24'd0,          1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   24'd1,          1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   -24'sd1,        1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   24'sd8388607,   1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   -24'sd8388608,  1'b0, 18'd0},
        '{scp_pkg::OP_COSINE, 24'sd8388607,   1'b0, 18'd0},
        '{scp_pkg::OP_COSINE, -24'sd8388608,  1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   24'sd205887,    1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   24'sd205888,    1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   -24'sd205887,   1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   -24'sd205888,   1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   24'sd102944,    1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   -24'sd102944,   1'b0, 18'd0},
        '{scp_pkg::OP_COSINE, 24'sd102943,    1'b0, 18'd0},
        '{scp_pkg::OP_COSINE, 24'sd102944,    1'b0, 18'd0},
        '{scp_pkg::OP_COSINE, -24'sd308830,   1'b0, 18'd0},
        '{scp_pkg::OP_COSINE, -24'sd308831,   1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   24'sd411775,    1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   24'sd617662,    1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   24'sd617663,    1'b0, 18'd0},
        '{scp_pkg::OP_SINE,   24'h555555,     1'b0, 18'd0},
        '{scp_pkg::OP_COSINE, 24'hAAAAAA,     1'b0, 18'd0}
    };

    t_sincos_word pending_results[$];
    int           mismatches  = 0;
    int           cycle_count = 0;
    bit           calm        = 1'b0;

    sine_cosine_polynomial dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // divide by 2^n, round to nearest with ties toward plus infinity
    function automatic longint round_pow2(longint p, int n);
        return (p + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint mul_q28(longint a, longint b);
        return round_pow2(a * b, 28);
    endfunction

    // expected q2.16 sine or cosine of a q8.16 angle
    function automatic logic signed [17:0] sincos_expected(logic op, logic [23:0] ang);
        longint v, k, x, sq, t, r;
        v = longint'($signed(ang)) * 65536;
        if (op == scp_pkg::OP_COSINE) begin
            v += QUARTER_TURN_Q32;
        end
        // fold into [-pi, pi] by the fewest whole turns
        if (v > HALF_TURN_Q32) begin
            k = (v - HALF_TURN_Q32 + FULL_TURN_Q32 - 1) / FULL_TURN_Q32;
            v -= k * FULL_TURN_Q32;
        end else if (v < -HALF_TURN_Q32) begin
            k = (-HALF_TURN_Q32 - v + FULL_TURN_Q32 - 1) / FULL_TURN_Q32;
            v += k * FULL_TURN_Q32;
        end
        x  = round_pow2(v, 4);
        sq = mul_q28(x, x);
        t  = COEF5_Q28 - mul_q28(sq, COEF7_Q28);
        t  = COEF3_Q28 + mul_q28(sq, t);
        t  = UNIT_Q28 + mul_q28(sq, t);
        r  = round_pow2(mul_q28(x, t), 12);
        if (r > SAT_HIGH) begin
            r = SAT_HIGH;
        end
        if (r < SAT_LOW) begin
            r = SAT_LOW;
        end
        return 18'(r);
    endfunction

    // mix of full-range angles, a few turns either side of zero, and
    // angles right at multiples of pi where the folding changes
    function automatic logic [23:0] random_angle();
        int mode, k, offset;
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            return 24'($urandom);
        end else if (mode < 7) begin
            return 24'($urandom_range(0, 1647100)) - 24'd823550;
        end
        k      = $urandom_range(0, 80) - 40;
        offset = $urandom_range(0, 6) - 3;
        return 24'((k * 2058874) / 10 + offset);
    endfunction

    // offer one word, with random idle cycles first, and wait for it to go in
    task automatic send_angle(input logic op, input logic [23:0] ang,
                              input logic known, input logic [17:0] typed_result);
        t_sincos_word w;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 24'($urandom);
            s_axis_tuser  <= 1'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ang;
        s_axis_tuser  <= op;
        w.op     = op;
        w.angle  = ang;
        w.result = known ? typed_result : sincos_expected(op, ang);
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(w);
    endtask

    // result side: random back-pressure and in-order checking
    always @(posedge i_clk) begin
        t_sincos_word       w;
        logic signed [17:0] got;
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[17:0];
            if (pending_results.size() == 0) begin
                $error("unexpected result word %0d", got);
                mismatches++;
            end else begin
                w = pending_results.pop_front();
                if (got !== w.result) begin
                    $error("result: expected %0d, got %0d (opcode %0d, angle %0d)",
                           w.result, got, w.op, w.angle);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sine_cosine_polynomial regression: fail");
            $finish;
        end
    end

    initial begin
        logic op;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_angle(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].angle,
                       DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].result);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= CALM_FIRST) && (n <= CALM_LAST);
            op   = $urandom_range(0, 1) ? scp_pkg::OP_COSINE : scp_pkg::OP_SINE;
            send_angle(op, random_angle(), 1'b0, '0);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        // let the pipeline drain, then allow for stray words
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("sine_cosine_polynomial regression: pass");
        end else begin
            $display("sine_cosine_polynomial regression: fail");
        end
        $finish;
    end

endmodule
